@@ sv/grid_bilinear_interpolator_defines.svh @@
// assertion macros for the grid bilinear interpolator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH
`define GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, off while in reset
`define GBI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define GBI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gbi_pkg.sv @@
// shared types and constants of the grid bilinear interpolator
// no dependencies
package gbi_pkg;

    localparam int Q_W      = 32;
    localparam int SLOT_W   = 12;
    localparam int CFG_W    = 7;
    localparam int CELL_W   = 6;
    localparam int KIND_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int APB_DW   = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TABLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    // register indexes
    localparam logic REG_ROW_POINTS = 1'b0;
    localparam logic REG_COL_POINTS = 1'b1;

    // grid read address select
    localparam logic [2:0] RA_ZERO = 3'd0;
    localparam logic [2:0] RA_LAST = 3'd1;
    localparam logic [2:0] RA_MID  = 3'd2;
    localparam logic [2:0] RA_J    = 3'd3;
    localparam logic [2:0] RA_J1   = 3'd4;

    // cell index source
    localparam logic [1:0] JS_ZERO = 2'd0;
    localparam logic [1:0] JS_LAST = 2'd1;
    localparam logic [1:0] JS_LO   = 2'd2;

    // multiplier operand select
    localparam logic [1:0] MS_DMAG = 2'd0;
    localparam logic [1:0] MS_WW   = 2'd1;
    localparam logic [1:0] MS_WV   = 2'd2;

    typedef struct packed {
        logic       wr;
        logic       start;
        logic       axis;
        logic [2:0] raddr_sel;
        logic       search_init;
        logic       search_step;
        logic       j_set;
        logic [1:0] j_src;
        logic       gj_load;
        logic       w_load;
        logic [1:0] corner;
        logic       tidx_load;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       dmag_load;
        logic       acc_add;
        logic       div_start;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic x_le;
        logic x_ge;
        logic half_zero;
        logic degen;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

@@ sv/gbi_if.sv @@
// item and result channels of the grid bilinear interpolator
// depends on gbi_pkg
interface gbi_item_if;
    import gbi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [SLOT_W-1:0]        slot;
    logic signed [Q_W-1:0]    write_data;
    logic signed [Q_W-1:0]    query_x;
    logic signed [Q_W-1:0]    query_y;
    modport source (output valid, kind, slot, write_data, query_x, query_y, input ready);
    modport sink (input valid, kind, slot, write_data, query_x, query_y, output ready);
    modport monitor (input valid, ready, kind, slot, write_data, query_x, query_y);
endinterface

interface gbi_result_if;
    import gbi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [Q_W-1:0]    interpolated;
    logic [CELL_W-1:0]        cell_row;
    logic [CELL_W-1:0]        cell_col;
    logic                     degenerate_cell;
    logic                     saturated;
    modport source (output valid, interpolated, cell_row, cell_col, degenerate_cell,
                    saturated, input ready);
    modport sink (input valid, interpolated, cell_row, cell_col, degenerate_cell,
                  saturated, output ready);
    modport monitor (input valid, ready, interpolated, cell_row, cell_col,
                     degenerate_cell, saturated);
endinterface

@@ sv/grid_bilinear_interpolator.sv @@
// top level of the grid bilinear interpolator
// depends on gbi_pkg, gbi_if, gbi_ctrl, gbi_dp
//
// usage
//   i_item carries write items (row point, column point, table value) and
//   queries; o_result carries one result item per query, none per write.
//   both are valid/ready channels, an item moves when valid and ready are high.
//   row_points (0x0) and col_points (0x4) are set over the apb port; the user
//   must set them only while idle, the block itself does not enforce it.
// flow
//   ready stays high after a write, so writes stream back to back.
//   a query runs a clamped binary search on each axis, a product for the
//   cell area, then for each of 4 corners two 32-step shift-add products,
//   and a restoring divide, one quotient bit per cycle.
//   a zero-area cell skips the products and the divide.
// reset
//   synchronous, active low; both point counts go to 64, the result register
//   empties. grid and table memories keep no reset value and must be written.
// back-pressure
//   the finished result waits in an output register; the next item is taken
//   meanwhile, and a later query waits at its end until the register is free.
module grid_bilinear_interpolator #(
    parameter int ROW_MAX = 64,
    parameter int COL_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gbi_item_if.sink                      i_item,
    gbi_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbi_pkg::PADDR_W-1:0]   paddr,
    input  logic [gbi_pkg::APB_DW-1:0]    pwdata,
    output logic [gbi_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import gbi_pkg::*;

    localparam int AW = $clog2(((ROW_MAX > COL_MAX) ? ROW_MAX : COL_MAX) + 1);

    logic [CFG_W-1:0] r_row_points, r_col_points;
    logic [AW-1:0]    w_row_n, w_col_n;
    logic             w_cfg_wr, w_reg_sel;
    t_cmd             w_cmd;
    t_status          w_status;

    // apb registers, one register per 32-bit word, no wait states
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_points <= CFG_W'(64);
            r_col_points <= CFG_W'(64);
        end else if (w_cfg_wr) begin
            if (w_reg_sel == REG_ROW_POINTS) begin
                r_row_points <= pwdata[CFG_W-1:0];
            end else begin
                r_col_points <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (w_reg_sel == REG_ROW_POINTS) ? APB_DW'(r_row_points)
                                                  : APB_DW'(r_col_points);

    // point counts in use, held between two and the store depth
    assign w_row_n = (r_row_points < CFG_W'(2))      ? AW'(2) :
                     (32'(r_row_points) > ROW_MAX)   ? AW'(ROW_MAX) : AW'(r_row_points);
    assign w_col_n = (r_col_points < CFG_W'(2))      ? AW'(2) :
                     (32'(r_col_points) > COL_MAX)   ? AW'(COL_MAX) : AW'(r_col_points);

    gbi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_kind   (i_item.kind),
        .o_ready  (i_item.ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    gbi_dp #(
        .ROW_MAX (ROW_MAX),
        .COL_MAX (COL_MAX)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_kind            (i_item.kind),
        .i_slot            (i_item.slot),
        .i_write_data      (i_item.write_data),
        .i_query_x         (i_item.query_x),
        .i_query_y         (i_item.query_y),
        .i_row_n           (w_row_n),
        .i_col_n           (w_col_n),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_interpolated    (o_result.interpolated),
        .o_cell_row        (o_result.cell_row),
        .o_cell_col        (o_result.cell_col),
        .o_degenerate_cell (o_result.degenerate_cell),
        .o_saturated       (o_result.saturated)
    );

endmodule

@@ sv/gbi_ctrl.sv @@
// sequencer of the grid bilinear interpolator: search, products, divide
// depends on gbi_pkg
module gbi_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [gbi_pkg::KIND_W-1:0] i_kind,
    output logic                      o_ready,
    input  gbi_pkg::t_status          i_status,
    output gbi_pkg::t_cmd             o_cmd
);
    import gbi_pkg::*;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_G0_RD     = 5'd1;
    localparam logic [4:0] ST_G0_CK     = 5'd2;
    localparam logic [4:0] ST_GL_CK     = 5'd3;
    localparam logic [4:0] ST_LOOP      = 5'd4;
    localparam logic [4:0] ST_LCMP      = 5'd5;
    localparam logic [4:0] ST_J_RD      = 5'd6;
    localparam logic [4:0] ST_J1_RD     = 5'd7;
    localparam logic [4:0] ST_W_LD      = 5'd8;
    localparam logic [4:0] ST_DEG_CK    = 5'd9;
    localparam logic [4:0] ST_DMAG_WAIT = 5'd10;
    localparam logic [4:0] ST_T_IDX     = 5'd11;
    localparam logic [4:0] ST_MW_WAIT   = 5'd12;
    localparam logic [4:0] ST_MV_WAIT   = 5'd13;
    localparam logic [4:0] ST_DIV       = 5'd14;
    localparam logic [4:0] ST_DIV_WAIT  = 5'd15;
    localparam logic [4:0] ST_DONE      = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_axis, n_axis;
    logic [1:0] r_corner, n_corner;
    logic       w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_corner = r_corner;
        o_cmd        = '0;
        o_cmd.axis   = r_axis;
        o_cmd.corner = r_corner;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_axis      = 1'b0;
                        n_state     = ST_G0_RD;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_G0_RD: begin
                o_cmd.raddr_sel = RA_ZERO;
                n_state         = ST_G0_CK;
            end
            ST_G0_CK: begin
                // first point is on the bus, fetch next-to-last meanwhile
                o_cmd.raddr_sel = RA_LAST;
                if (i_status.x_le) begin
                    o_cmd.j_set = 1'b1;
                    o_cmd.j_src = JS_ZERO;
                    n_state     = ST_J_RD;
                end else begin
                    n_state = ST_GL_CK;
                end
            end
            ST_GL_CK: begin
                if (i_status.x_ge) begin
                    o_cmd.j_set = 1'b1;
                    o_cmd.j_src = JS_LAST;
                    n_state     = ST_J_RD;
                end else begin
                    o_cmd.search_init = 1'b1;
                    n_state           = ST_LOOP;
                end
            end
            ST_LOOP: begin
                o_cmd.raddr_sel = RA_MID;
                if (i_status.half_zero) begin
                    o_cmd.j_set = 1'b1;
                    o_cmd.j_src = JS_LO;
                    n_state     = ST_J_RD;
                end else begin
                    n_state = ST_LCMP;
                end
            end
            ST_LCMP: begin
                o_cmd.search_step = 1'b1;
                n_state           = ST_LOOP;
            end
            ST_J_RD: begin
                o_cmd.raddr_sel = RA_J;
                n_state         = ST_J1_RD;
            end
            ST_J1_RD: begin
                o_cmd.gj_load   = 1'b1;
                o_cmd.raddr_sel = RA_J1;
                n_state         = ST_W_LD;
            end
            ST_W_LD: begin
                o_cmd.w_load = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = ST_G0_RD;
                end else begin
                    n_state = ST_DEG_CK;
                end
            end
            ST_DEG_CK: begin
                if (i_status.degen) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_DMAG;
                    n_state         = ST_DMAG_WAIT;
                end
            end
            ST_DMAG_WAIT: begin
                if (!i_status.mul_busy) begin
                    o_cmd.dmag_load = 1'b1;
                    n_corner        = 2'd0;
                    n_state         = ST_T_IDX;
                end
            end
            ST_T_IDX: begin
                // table index and weight product start together
                o_cmd.tidx_load = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_WW;
                n_state         = ST_MW_WAIT;
            end
            ST_MW_WAIT: begin
                if (!i_status.mul_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_WV;
                    n_state         = ST_MV_WAIT;
                end
            end
            ST_MV_WAIT: begin
                if (!i_status.mul_busy) begin
                    o_cmd.acc_add = 1'b1;
                    if (r_corner == 2'd3) begin
                        n_state = ST_DIV;
                    end else begin
                        n_corner = r_corner + 2'd1;
                        n_state  = ST_T_IDX;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_axis   <= 1'b0;
            r_corner <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_corner <= n_corner;
        end
    end

endmodule

@@ sv/gbi_dp.sv @@
// datapath: grid and table memories, search unit, serial multiplier, divider
// depends on gbi_pkg
module gbi_dp #(
    parameter int ROW_MAX = 64,
    parameter int COL_MAX = 64,
    localparam int AW = $clog2(((ROW_MAX > COL_MAX) ? ROW_MAX : COL_MAX) + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbi_pkg::t_cmd               i_cmd,
    output gbi_pkg::t_status            o_status,
    input  logic [gbi_pkg::KIND_W-1:0]  i_kind,
    input  logic [gbi_pkg::SLOT_W-1:0]  i_slot,
    input  logic signed [gbi_pkg::Q_W-1:0] i_write_data,
    input  logic signed [gbi_pkg::Q_W-1:0] i_query_x,
    input  logic signed [gbi_pkg::Q_W-1:0] i_query_y,
    input  logic [AW-1:0]               i_row_n,
    input  logic [AW-1:0]               i_col_n,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [gbi_pkg::Q_W-1:0] o_interpolated,
    output logic [gbi_pkg::CELL_W-1:0]  o_cell_row,
    output logic [gbi_pkg::CELL_W-1:0]  o_cell_col,
    output logic                        o_degenerate_cell,
    output logic                        o_saturated
);
    import gbi_pkg::*;

    localparam int RW        = $clog2(ROW_MAX);
    localparam int CW        = $clog2(COL_MAX);
    localparam int TD        = ROW_MAX * COL_MAX;
    localparam int TW        = $clog2(TD);
    localparam int MUL_STEPS = 32;
    localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
    localparam int SUM_W     = 128;
    localparam int DCNT_W    = $clog2(SUM_W + 1);

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] u;
        u = v[32] ? 33'(-v) : 33'(v);
        return u[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // stores
    logic signed [Q_W-1:0] r_row_mem [ROW_MAX];
    logic signed [Q_W-1:0] r_col_mem [COL_MAX];
    logic signed [Q_W-1:0] r_tab_mem [TD];
    logic signed [Q_W-1:0] r_row_rd, r_col_rd, r_tab_rd;

    // search
    logic signed [Q_W-1:0] r_qx, r_qy, w_x, w_rd, r_gj;
    logic [AW-1:0] r_lo, r_len, w_half, w_mid, w_n, w_last, w_jlo, w_jcur, w_raddr;
    logic [AW-1:0] r_j [2];
    logic signed [32:0] r_wa [2];
    logic signed [32:0] r_wb [2];
    logic signed [32:0] r_d  [2];

    // products
    logic [TW-1:0]  r_tidx;
    logic [31:0]    w_tidx_full;
    logic           w_k1, w_k2;
    logic signed [32:0] w_w1, w_w2;
    logic [63:0]    w_ma_sel;
    logic [31:0]    w_mb_sel;
    logic [95:0]    r_ma, r_macc;
    logic [31:0]    r_mb;
    logic [MCNT_W-1:0] r_mcnt;
    logic [63:0]    r_dmag;
    logic [SUM_W-1:0] r_sum, w_term;
    logic           w_neg;

    // divide
    logic [SUM_W-1:0]  r_num;
    logic [63:0]       r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_nneg;
    logic [64:0]       w_dsh, w_dsub;
    logic              w_dge;

    // result
    logic              w_degen, w_rneg, w_sat;
    logic signed [Q_W-1:0] w_res;
    logic              r_ovalid;

    assign w_x    = i_cmd.axis ? r_qy : r_qx;
    assign w_rd   = i_cmd.axis ? r_col_rd : r_row_rd;
    assign w_n    = i_cmd.axis ? i_col_n : i_row_n;
    assign w_last = w_n - AW'(2);
    assign w_half = r_len >> 1;
    assign w_mid  = r_lo + w_half;
    assign w_jlo  = (r_lo > w_last) ? w_last : r_lo;
    assign w_jcur = r_j[i_cmd.axis];

    always_comb begin
        case (i_cmd.raddr_sel)
            RA_ZERO: w_raddr = '0;
            RA_LAST: w_raddr = w_last;
            RA_MID:  w_raddr = w_mid;
            RA_J:    w_raddr = w_jcur;
            RA_J1:   w_raddr = w_jcur + AW'(1);
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_kind == KIND_ROW && 32'(i_slot) < ROW_MAX) begin
            r_row_mem[i_slot[RW-1:0]] <= i_write_data;
        end
        r_row_rd <= r_row_mem[w_raddr[RW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_kind == KIND_COL && 32'(i_slot) < COL_MAX) begin
            r_col_mem[i_slot[CW-1:0]] <= i_write_data;
        end
        r_col_rd <= r_col_mem[w_raddr[CW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_kind == KIND_TABLE && 32'(i_slot) < TD) begin
            r_tab_mem[TW'(i_slot)] <= i_write_data;
        end
        r_tab_rd <= r_tab_mem[r_tidx];
    end

    // search and cell edges
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
        end
        if (i_cmd.search_init) begin
            r_lo  <= '0;
            r_len <= w_n;
        end else if (i_cmd.search_step) begin
            if (w_rd <= w_x) begin
                r_lo <= w_mid;
            end
            r_len <= r_len - w_half;
        end
        if (i_cmd.j_set) begin
            case (i_cmd.j_src)
                JS_ZERO: r_j[i_cmd.axis] <= '0;
                JS_LAST: r_j[i_cmd.axis] <= w_last;
                JS_LO:   r_j[i_cmd.axis] <= w_jlo;
                default: r_j[i_cmd.axis] <= '0;
            endcase
        end
        if (i_cmd.gj_load) begin
            r_gj <= w_rd;
        end
        if (i_cmd.w_load) begin
            r_wa[i_cmd.axis] <= {w_rd[31], w_rd} - {w_x[31], w_x};
            r_wb[i_cmd.axis] <= {w_x[31], w_x} - {r_gj[31], r_gj};
            r_d[i_cmd.axis]  <= {w_rd[31], w_rd} - {r_gj[31], r_gj};
        end
    end

    // corner selection: bit 1 picks the row edge, bit 0 the column edge
    assign w_k1 = i_cmd.corner[1];
    assign w_k2 = i_cmd.corner[0];
    assign w_w1 = w_k1 ? r_wb[0] : r_wa[0];
    assign w_w2 = w_k2 ? r_wb[1] : r_wa[1];
    assign w_tidx_full = (32'(r_j[0]) + 32'(w_k1)) * 32'(i_col_n)
                       + 32'(r_j[1]) + 32'(w_k2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tidx_load) begin
            r_tidx <= w_tidx_full[TW-1:0];
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MS_DMAG: begin
                w_ma_sel = 64'(mag33(r_d[0]));
                w_mb_sel = mag33(r_d[1]);
            end
            MS_WW: begin
                w_ma_sel = 64'(mag33(w_w1));
                w_mb_sel = mag33(w_w2);
            end
            MS_WV: begin
                w_ma_sel = r_macc[63:0];
                w_mb_sel = mag32(r_tab_rd);
            end
            default: begin
                w_ma_sel = '0;
                w_mb_sel = '0;
            end
        endcase
    end

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma   <= 96'(w_ma_sel);
            r_mb   <= w_mb_sel;
            r_macc <= '0;
        end else if (r_mcnt != '0) begin
            if (r_mb[0]) begin
                r_macc <= r_macc + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_cmd.mul_start) begin
            r_mcnt <= MCNT_W'(MUL_STEPS);
        end else if (r_mcnt != '0) begin
            r_mcnt <= r_mcnt - MCNT_W'(1);
        end
    end

    assign w_neg  = w_w1[32] ^ w_w2[32] ^ r_tab_rd[31];
    assign w_term = SUM_W'(r_macc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.dmag_load) begin
            r_dmag <= r_macc[63:0];
        end
        if (i_cmd.start) begin
            r_sum <= '0;
        end else if (i_cmd.acc_add) begin
            r_sum <= w_neg ? r_sum - w_term : r_sum + w_term;
        end
    end

    // restoring divide of the sum magnitude by the area, one quotient bit a cycle
    assign w_dsh  = {r_rem, r_num[SUM_W-1]};
    assign w_dge  = w_dsh >= {1'b0, r_dmag};
    assign w_dsub = w_dsh - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_nneg <= r_sum[SUM_W-1];
            r_num  <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
            r_rem  <= '0;
        end else if (r_dcnt != '0) begin
            r_rem <= w_dge ? w_dsub[63:0] : w_dsh[63:0];
            r_num <= {r_num[SUM_W-2:0], w_dge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCNT_W'(SUM_W);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    // sign, clamp and degenerate handling
    assign w_degen = (r_d[0] == '0) || (r_d[1] == '0);
    assign w_rneg  = r_nneg ^ r_d[0][32] ^ r_d[1][32];

    always_comb begin
        w_res = '0;
        w_sat = 1'b0;
        if (w_degen) begin
            w_res = '0;
        end else if (w_rneg) begin
            if ((|r_num[SUM_W-1:32]) || r_num[31:0] > 32'h8000_0000) begin
                w_res = 32'sh8000_0000;
                w_sat = 1'b1;
            end else begin
                w_res = 32'(32'd0 - r_num[31:0]);
            end
        end else begin
            if (|r_num[SUM_W-1:31]) begin
                w_res = 32'sh7fff_ffff;
                w_sat = 1'b1;
            end else begin
                w_res = r_num[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_interpolated    <= w_res;
            o_cell_row        <= CELL_W'(r_j[0]);
            o_cell_col        <= CELL_W'(r_j[1]);
            o_degenerate_cell <= w_degen;
            o_saturated       <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;

    always_comb begin
        o_status           = '0;
        o_status.x_le      = w_x <= w_rd;
        o_status.x_ge      = w_x >= w_rd;
        o_status.half_zero = (w_half == '0);
        o_status.degen     = w_degen;
        o_status.mul_busy  = (r_mcnt != '0);
        o_status.div_busy  = (r_dcnt != '0);
        o_status.out_free  = !r_ovalid || i_out_ready;
    end

endmodule

@@ sv/gbi_checker.sv @@
// port-level checks of the grid bilinear interpolator, bound to the top level
// depends on gbi_if and grid_bilinear_interpolator_defines.svh
`include "grid_bilinear_interpolator_defines.svh"

module gbi_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    gbi_item_if.sink     i_item,
    gbi_result_if.source i_result
);

    // a stalled result keeps its value
    `GBI_ASSERT_NXT(a_result_hold, i_result.valid && !i_result.ready, i_result.valid && $stable(i_result.interpolated), "result changed while stalled")

    // no result can appear right after an item is taken
    `GBI_ASSERT_NXT(a_no_result_after_accept, i_item.valid && i_item.ready, !$rose(i_result.valid), "result rose right after an item was taken")

    // a zero-area cell gives zero and no clamp
    `GBI_ASSERT_IMP(a_degen_zero, i_result.valid && i_result.degenerate_cell, i_result.interpolated == 32'sd0 && !i_result.saturated, "degenerate cell with nonzero result")

    // a clamped result sits at one of the two limits
    `GBI_ASSERT_IMP(a_sat_limit, i_result.valid && i_result.saturated, i_result.interpolated == 32'sh7fff_ffff || i_result.interpolated == 32'sh8000_0000, "saturated result off the limits")

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_item   (i_item),
    .i_result (o_result)
);

@@ tb/tb_top.sv @@
// self-checking testbench for grid_bilinear_interpolator
// depends on gbi_pkg, gbi_if and the block's rtl
`timescale 1ns / 100ps

module tb_top;
    import gbi_pkg::*;

    localparam int GRID_N  = 64;
    localparam int TAB_N   = GRID_N * GRID_N;
    localparam int DRAIN   = 700;          // cycles of one slow query and some margin
    localparam int IDLE_PC = 13;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic signed [Q_W-1:0] wdata;
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
    } t_grid_item;

    typedef struct {
        logic signed [Q_W-1:0] value;
        logic [CELL_W-1:0]     row;
        logic [CELL_W-1:0]     col;
        logic                  degen;
        logic                  sat;
    } t_interp_res;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    gbi_item_if   item_ch ();
    gbi_result_if res_ch ();

    grid_bilinear_interpolator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // stimulus queue and expected interpolation results
    t_grid_item  pending_items[$];
    t_interp_res interp_expected[$];

    // predictor copy of the block: follows accepted items and register writes
    logic signed [Q_W-1:0] pr_row[GRID_N];
    logic signed [Q_W-1:0] pr_col[GRID_N];
    logic signed [Q_W-1:0] pr_tab[TAB_N];
    int pr_row_pts, pr_col_pts;

    // planning copy: follows queued items, used to keep queries off unwritten entries
    logic signed [Q_W-1:0] pl_row[GRID_N];
    logic signed [Q_W-1:0] pl_col[GRID_N];
    bit                    pl_tab_written[TAB_N];
    int pl_row_pts, pl_col_pts;

    bit calm;          // no idling on either side while set
    int fail_cnt, query_cnt, degen_cnt, sat_cnt, phase_cnt;

    // clock and timeout
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #32000000;
        $display("tb: failure");
        $finish;
    end

    // grid point lookup, sel picks predictor/plan copy and axis
    function automatic logic signed [Q_W-1:0] grid_pt(input int sel, input int idx);
        case (sel)
            0: return pr_row[idx];
            1: return pr_col[idx];
            2: return pl_row[idx];
            default: return pl_col[idx];
        endcase
    endfunction

    // point counts saturate to 2..64
    function automatic int eff_points(input int r);
        if (r < 2) return 2;
        if (r > GRID_N) return GRID_N;
        return r;
    endfunction

    // lower cell index by binary search, clamped at both ends
    function automatic int find_cell(input int sel, input int n, input logic signed [Q_W-1:0] x);
        int lo, len, half, mid;
        lo = 0;
        len = n;
        if (x <= grid_pt(sel, 0)) return 0;
        if (x >= grid_pt(sel, n - 2)) return n - 2;
        half = len / 2;
        while (half != 0) begin
            mid = lo + half;
            if (grid_pt(sel, mid) <= x) lo = mid;
            len = len - half;
            half = len / 2;
        end
        return (lo > n - 2) ? n - 2 : lo;
    endfunction

    // bilinear value of one query against the predictor state
    function automatic t_interp_res interpolate(input logic signed [Q_W-1:0] x,
                                                input logic signed [Q_W-1:0] y);
        t_interp_res r;
        int nr, nc, j1, j2, k1, k2;
        logic signed [127:0] xs, ys, lo_x, hi_x, lo_y, hi_y, v, acc, den, quo;
        logic signed [127:0] wx[2];
        logic signed [127:0] wy[2];
        nr = eff_points(pr_row_pts);
        nc = eff_points(pr_col_pts);
        j1 = find_cell(0, nr, x);
        j2 = find_cell(1, nc, y);
        xs = x;
        ys = y;
        lo_x = pr_row[j1];
        hi_x = pr_row[j1 + 1];
        lo_y = pr_col[j2];
        hi_y = pr_col[j2 + 1];
        wx[0] = hi_x - xs;
        wx[1] = xs - lo_x;
        wy[0] = hi_y - ys;
        wy[1] = ys - lo_y;
        den = (hi_x - lo_x) * (hi_y - lo_y);
        r.row = j1[CELL_W-1:0];
        r.col = j2[CELL_W-1:0];
        r.value = '0;
        r.sat = 1'b0;
        r.degen = (hi_x == lo_x) || (hi_y == lo_y);
        if (!r.degen) begin
            acc = '0;
            for (k1 = 0; k1 < 2; k1++)
                for (k2 = 0; k2 < 2; k2++) begin
                    v = pr_tab[(j1 + k1) * nc + j2 + k2];
                    acc = acc + wx[k1] * wy[k2] * v;
                end
            // signed divide truncates toward zero
            quo = acc / den;
            if (quo > 128'sh7FFF_FFFF) begin
                r.value = 32'h7FFF_FFFF;
                r.sat = 1'b1;
            end else if (quo < -128'sh8000_0000) begin
                r.value = 32'h8000_0000;
                r.sat = 1'b1;
            end else begin
                r.value = quo[Q_W-1:0];
            end
        end
        return r;
    endfunction

    // item driver: next item goes out when the channel is free, with random gaps
    always @(posedge i_clk) begin
        t_grid_item it;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_ch.ready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PC)) begin
                it = pending_items.pop_front();
                item_ch.valid      <= 1'b1;
                item_ch.kind       <= it.kind;
                item_ch.slot       <= it.slot;
                item_ch.write_data <= it.wdata;
                item_ch.query_x    <= it.qx;
                item_ch.query_y    <= it.qy;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PC);
    end

    // monitor: check results first, then predict the item taken at this edge
    always @(posedge i_clk) begin
        t_interp_res want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (interp_expected.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result value=%h row=%0d col=%0d", $time,
                             res_ch.interpolated, res_ch.cell_row, res_ch.cell_col);
                end else begin
                    want = interp_expected.pop_front();
                    query_cnt++;
                    if (want.degen) degen_cnt++;
                    if (want.sat) sat_cnt++;
                    if (res_ch.interpolated !== want.value || res_ch.cell_row !== want.row ||
                        res_ch.cell_col !== want.col || res_ch.degenerate_cell !== want.degen ||
                        res_ch.saturated !== want.sat) begin
                        fail_cnt++;
                        $display("%0t: mismatch exp v=%h r=%0d c=%0d d=%b s=%b got v=%h r=%0d c=%0d d=%b s=%b",
                                 $time, want.value, want.row, want.col, want.degen, want.sat,
                                 res_ch.interpolated, res_ch.cell_row, res_ch.cell_col,
                                 res_ch.degenerate_cell, res_ch.saturated);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                case (item_ch.kind)
                    KIND_ROW: if (item_ch.slot < GRID_N) pr_row[item_ch.slot] = item_ch.write_data;
                    KIND_COL: if (item_ch.slot < GRID_N) pr_col[item_ch.slot] = item_ch.write_data;
                    KIND_TABLE: pr_tab[item_ch.slot] = item_ch.write_data;
                    default: interp_expected.push_back(interpolate(item_ch.query_x, item_ch.query_y));
                endcase
            end
        end
    end

    // queue one item and track it in the planning copy
    task automatic put_item(input logic [KIND_W-1:0] k, input int slot,
                            input logic signed [Q_W-1:0] d,
                            input logic signed [Q_W-1:0] x, input logic signed [Q_W-1:0] y);
        t_grid_item it;
        it.kind = k;
        it.slot = slot[SLOT_W-1:0];
        it.wdata = d;
        it.qx = x;
        it.qy = y;
        if (k == KIND_ROW && slot < GRID_N) pl_row[slot] = d;
        if (k == KIND_COL && slot < GRID_N) pl_col[slot] = d;
        if (k == KIND_TABLE) pl_tab_written[slot] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic put_write(input logic [KIND_W-1:0] k, input int slot,
                             input logic signed [Q_W-1:0] d);
        put_item(k, slot, d, $urandom, $urandom);
    endtask

    // query, preceded by writes to any corner of its nonzero-area cell not yet written
    task automatic put_query(input logic signed [Q_W-1:0] x, input logic signed [Q_W-1:0] y);
        int nr, nc, j1, j2, k1, k2, idx;
        nr = eff_points(pl_row_pts);
        nc = eff_points(pl_col_pts);
        j1 = find_cell(2, nr, x);
        j2 = find_cell(3, nc, y);
        if (pl_row[j1] != pl_row[j1 + 1] && pl_col[j2] != pl_col[j2 + 1])
            for (k1 = 0; k1 < 2; k1++)
                for (k2 = 0; k2 < 2; k2++) begin
                    idx = (j1 + k1) * nc + j2 + k2;
                    if (!pl_tab_written[idx]) put_write(KIND_TABLE, idx, $urandom);
                end
        put_item(KIND_QUERY, 0, $urandom, x, y);
    endtask

    // grid of n points: 0 ascending, 1 ascending with repeats, 2 arbitrary
    task automatic fill_grid(input logic [KIND_W-1:0] k, input int n, input int mode);
        longint step_max, pt;
        int i;
        step_max = longint'(1) << $urandom_range(24);
        pt = -32 * step_max + $urandom_range(0, int'(step_max > 1000 ? 1000 : step_max));
        for (i = 0; i < n; i++) begin
            if (mode == 2) put_write(k, i, $urandom);
            else put_write(k, i, pt[Q_W-1:0]);
            if (mode == 1 && $urandom_range(3) == 0) pt = pt;
            else pt = pt + 1 + ($urandom % step_max);
        end
    endtask

    // random coordinate: mostly inside the grid span, some far out, some extreme
    function automatic logic signed [Q_W-1:0] pick_coord(input int sel, input int n);
        longint lo, hi;
        int c;
        c = $urandom_range(99);
        lo = grid_pt(sel, 0);
        hi = grid_pt(sel, n - 1);
        if (c < 8) return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (c < 25 || hi <= lo) return $urandom;
        if (c < 30) return grid_pt(sel, $urandom_range(n - 1));
        return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    endfunction

    // config write over apb, only while the block is idle
    task automatic apb_write(input logic reg_idx, input logic [APB_DW-1:0] d);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_ROW_POINTS) pr_row_pts = int'(d[CFG_W-1:0]);
        else pr_col_pts = int'(d[CFG_W-1:0]);
    endtask

    task automatic drain;
        while (pending_items.size() != 0 || interp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_points(input int r, input int c);
        drain();
        apb_write(REG_ROW_POINTS, r);
        apb_write(REG_COL_POINTS, c);
        pl_row_pts = r & 7'h7F;
        pl_col_pts = c & 7'h7F;
        phase_cnt++;
    endtask

    // one random phase: fresh grids, then a mix of queries, writes and noise
    task automatic random_phase(input int r, input int c, input int mode, input int cnt);
        int nr, nc, i, p;
        set_points(r, c);
        nr = eff_points(pl_row_pts);
        nc = eff_points(pl_col_pts);
        fill_grid(KIND_ROW, nr, mode);
        fill_grid(KIND_COL, nc, mode);
        for (i = 0; i < cnt; i++) begin
            p = $urandom_range(99);
            if (p < 50) put_query(pick_coord(2, nr), pick_coord(3, nc));
            else if (p < 82)
                put_write(KIND_TABLE, $urandom_range(nr - 1) * nc + $urandom_range(nc - 1), $urandom);
            else if (p < 88) put_write(KIND_TABLE, $urandom_range(TAB_N - 1), $urandom);
            else if (p < 93) put_write(KIND_ROW, $urandom_range(4095), $urandom);
            else put_write(KIND_COL, $urandom_range(4095), $urandom);
        end
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_ROW;
        item_ch.slot = '0;
        item_ch.write_data = '0;
        item_ch.query_x = '0;
        item_ch.query_y = '0;
        res_ch.ready = 1'b0;
        pr_row_pts = GRID_N;
        pr_col_pts = GRID_N;
        pl_row_pts = GRID_N;
        pl_col_pts = GRID_N;
        for (i = 0; i < TAB_N; i++) pl_tab_written[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full ascending grids at reset counts, edge queries and ignored writes
        fill_grid(KIND_ROW, GRID_N, 0);
        fill_grid(KIND_COL, GRID_N, 0);
        put_write(KIND_TABLE, 0, 32'sh7FFF_FFFF);
        put_write(KIND_TABLE, TAB_N - 1, 32'sh8000_0000);
        put_write(KIND_TABLE, 1, 32'sh0);
        put_write(KIND_ROW, GRID_N, 32'sh7FFF_FFFF);
        put_write(KIND_ROW, 4095, 32'sh8000_0000);
        put_write(KIND_COL, 100, 32'sh0);
        put_query(pl_row[0], pl_col[0]);
        put_query(32'sh8000_0000, 32'sh8000_0000);
        put_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        put_query(pl_row[62], pl_col[63]);
        put_query(pl_row[1] - 1, pl_col[31]);
        put_query(32'sh0, 32'sh7FFF_FFFF);
        put_query(32'shFFFF_FFFF, 32'sh0);

        // directed: two-point grids spanning the whole coordinate range, then a flat cell
        set_points(2, 2);
        put_write(KIND_ROW, 0, 32'sh8000_0000);
        put_write(KIND_ROW, 1, 32'sh7FFF_FFFF);
        put_write(KIND_COL, 0, 32'sh8000_0000);
        put_write(KIND_COL, 1, 32'sh7FFF_FFFF);
        put_query(32'sh8000_0000, 32'sh7FFF_FFFF);
        put_query(32'sh0, 32'sh0);
        put_write(KIND_COL, 1, 32'sh8000_0000);
        put_query(32'sh1234_5678, 32'sh0);

        // random phases over several point counts, the extremes among them
        random_phase(0, 1, 0, 60);
        random_phase(127, 127, 0, 70);
        calm = 1'b1;
        random_phase(64, 64, 1, 60);
        calm = 1'b0;
        random_phase(5, 37, 0, 55);
        random_phase(64, 2, 2, 50);
        random_phase(3, 64, 1, 55);
        random_phase($urandom_range(2, 64), $urandom_range(2, 64), 0, 55);
        random_phase($urandom_range(2, 127), $urandom_range(2, 127), 0, 55);
        drain();

        $display("tb: %0d queries checked over %0d point-count settings", query_cnt, phase_cnt + 1);
        $display("tb: %0d zero-area cells, %0d clamped results, %0d errors",
                 degen_cnt, sat_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
